>>> src/stptx_pkg.sv
// Shared types, state codes and field codes of the port transmit machine.
// No dependencies; stptx_csr, stptx_eval and the top level import this package.
package stptx_pkg;

   // State codes
   localparam logic [2:0] ST_INIT     = 3'd0;
   localparam logic [2:0] ST_PERIODIC = 3'd1;
   localparam logic [2:0] ST_CONFIG   = 3'd2;
   localparam logic [2:0] ST_TCN      = 3'd3;
   localparam logic [2:0] ST_RSTP     = 3'd4;
   localparam logic [2:0] ST_AGREE    = 3'd5;
   localparam logic [2:0] ST_IDLE     = 3'd6;
   localparam logic [2:0] ST_UNUSED   = 3'd7;

   // BPDU kinds reported in transmit_kind
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_CONFIG = 2'd1;
   localparam logic [1:0] KIND_TCN    = 2'd2;
   localparam logic [1:0] KIND_RSTP   = 2'd3;

   // CIST role codes
   localparam logic [1:0] ROLE_DESIG = 2'd1;
   localparam logic [1:0] ROLE_ROOT  = 2'd2;

   // Bit positions in flag_updates
   localparam int FU_SET_NEW_INFO   = 0;
   localparam int FU_SET_NEW_MSTI   = 1;
   localparam int FU_CLR_AGREE      = 2;

   // Register indexes and reset values
   localparam logic REG_TX_HOLD_COUNT = 1'b0;
   localparam logic REG_HELLO_TIME    = 1'b1;
   localparam logic [3:0] TX_HOLD_COUNT_RESET = 4'd6;
   localparam logic [3:0] HELLO_TIME_RESET    = 4'd2;

   typedef struct packed {
      logic       begin_req;
      logic       port_enabled;
      logic       enable_bpdu_tx;
      logic       all_transmit_ready;
      logic [1:0] cist_role;
      logic       msti_master;
      logic       msti_desig_or_tc_root;
      logic       cist_tc_active;
      logic       spt_all_agree;
      logic       send_rstp;
      logic       tick;
      logic [2:0] flag_updates;
   } req_word_type;

   typedef struct packed {
      logic [2:0] fsm_state_out;
      logic [1:0] transmit_kind;
      logic [3:0] tx_count_out;
      logic       new_info_out;
      logic       new_info_msti_out;
      logic       tc_ack_clear;
      logic       agree_digest_out;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] fsm_state;
      logic       new_info;
      logic       new_info_msti;
      logic [3:0] tx_count;
      logic [3:0] hello_countdown;
      logic       agree_digest_valid;
   } port_state_type;

   typedef struct packed {
      logic [3:0] tx_hold_count;
      logic [3:0] hello_time;
   } cfg_type;

endpackage

>>> src/stptx_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on nothing; payload fields match the package word structs.
interface stptx_req_if;
   logic       valid;
   logic       ready;
   logic       begin_req;
   logic       port_enabled;
   logic       enable_bpdu_tx;
   logic       all_transmit_ready;
   logic [1:0] cist_role;
   logic       msti_master;
   logic       msti_desig_or_tc_root;
   logic       cist_tc_active;
   logic       spt_all_agree;
   logic       send_rstp;
   logic       tick;
   logic [2:0] flag_updates;

   modport source (
      output valid, begin_req, port_enabled, enable_bpdu_tx, all_transmit_ready,
             cist_role, msti_master, msti_desig_or_tc_root, cist_tc_active,
             spt_all_agree, send_rstp, tick, flag_updates,
      input  ready
   );
   modport sink (
      input  valid, begin_req, port_enabled, enable_bpdu_tx, all_transmit_ready,
             cist_role, msti_master, msti_desig_or_tc_root, cist_tc_active,
             spt_all_agree, send_rstp, tick, flag_updates,
      output ready
   );
endinterface

interface stptx_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] fsm_state_out;
   logic [1:0] transmit_kind;
   logic [3:0] tx_count_out;
   logic       new_info_out;
   logic       new_info_msti_out;
   logic       tc_ack_clear;
   logic       agree_digest_out;

   modport source (
      output valid, fsm_state_out, transmit_kind, tx_count_out, new_info_out,
             new_info_msti_out, tc_ack_clear, agree_digest_out,
      input  ready
   );
   modport sink (
      input  valid, fsm_state_out, transmit_kind, tx_count_out, new_info_out,
             new_info_msti_out, tc_ack_clear, agree_digest_out,
      output ready
   );
endinterface

>>> src/stptx_csr.sv
// APB-style configuration registers: transmit hold count and hello time.
// Depends on stptx_pkg.
module stptx_csr
   import stptx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [2:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready,
   output cfg_type     cfg
);

   logic [3:0] tx_hold_count_ff, tx_hold_count_in;
   logic [3:0] hello_time_ff, hello_time_in;
   logic       wr_en;
   logic       reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite & pready;
   assign reg_sel = paddr[2];

   always_comb begin
      tx_hold_count_in = tx_hold_count_ff;
      hello_time_in    = hello_time_ff;
      if (wr_en) begin
         if (reg_sel == REG_TX_HOLD_COUNT) tx_hold_count_in = pwdata[3:0];
         else                              hello_time_in    = pwdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_hold_count_ff <= TX_HOLD_COUNT_RESET;
         hello_time_ff    <= HELLO_TIME_RESET;
      end else begin
         tx_hold_count_ff <= tx_hold_count_in;
         hello_time_ff    <= hello_time_in;
      end
   end

   assign prdata = (reg_sel == REG_TX_HOLD_COUNT) ? {28'd0, tx_hold_count_ff}
                                                  : {28'd0, hello_time_ff};
   assign cfg.tx_hold_count = tx_hold_count_ff;
   assign cfg.hello_time    = hello_time_ff;

endmodule

>>> src/stptx_eval.sv
// One evaluation of the port transmit machine: tick, flag updates,
// at most one transition and its entry actions. Depends on stptx_pkg.
module stptx_eval
   import stptx_pkg::*;
(
   input  port_state_type cur_state,
   input  req_word_type   word,
   input  cfg_type        cfg,
   output port_state_type nxt_state,
   output rsp_word_type   result
);

   port_state_type s;
   logic           desig, root, room, move;
   logic [2:0]     target;
   logic [1:0]     kind;
   logic           tcack;

   always_comb begin
      desig  = (word.cist_role == ROLE_DESIG);
      root   = (word.cist_role == ROLE_ROOT);
      s      = cur_state;
      move   = 1'b0;
      target = ST_IDLE;
      kind   = KIND_NONE;
      tcack  = 1'b0;

      if (word.tick) begin
         if (s.hello_countdown != 4'd0) s.hello_countdown = s.hello_countdown - 4'd1;
         if (s.tx_count != 4'd0)        s.tx_count        = s.tx_count - 4'd1;
      end
      if (word.flag_updates[FU_SET_NEW_INFO]) s.new_info           = 1'b1;
      if (word.flag_updates[FU_SET_NEW_MSTI]) s.new_info_msti      = 1'b1;
      if (word.flag_updates[FU_CLR_AGREE])    s.agree_digest_valid = 1'b0;

      room = (s.tx_count < cfg.tx_hold_count);

      // Pick the transition
      if (word.begin_req || !word.port_enabled || !word.enable_bpdu_tx) begin
         if (s.fsm_state != ST_INIT) begin
            move   = 1'b1;
            target = ST_INIT;
         end
      end else if (s.fsm_state inside {[ST_INIT:ST_AGREE]}) begin
         move   = 1'b1;
         target = ST_IDLE;
      end else if (word.all_transmit_ready) begin
         if (s.hello_countdown == 4'd0) begin
            move   = 1'b1;
            target = ST_PERIODIC;
         end else if (!word.send_rstp && s.new_info && desig && room) begin
            move   = 1'b1;
            target = ST_CONFIG;
         end else if (!word.send_rstp && s.new_info && root && room) begin
            move   = 1'b1;
            target = ST_TCN;
         end else if (word.send_rstp && room &&
                      (s.new_info || (s.new_info_msti && !word.msti_master))) begin
            move   = 1'b1;
            target = ST_RSTP;
         end else if (word.spt_all_agree && word.send_rstp && !s.agree_digest_valid) begin
            move   = 1'b1;
            target = ST_AGREE;
         end
      end

      // Entry actions
      if (move) begin
         s.fsm_state = target;
         case (target)
            ST_INIT: begin
               s.new_info      = 1'b1;
               s.new_info_msti = 1'b1;
               s.tx_count      = 4'd0;
            end
            ST_PERIODIC: begin
               s.new_info      = s.new_info | desig | (root & word.cist_tc_active);
               s.new_info_msti = s.new_info_msti | word.msti_desig_or_tc_root;
            end
            ST_CONFIG: begin
               s.new_info = 1'b0;
               s.tx_count = s.tx_count + 4'd1;
               kind       = KIND_CONFIG;
               tcack      = 1'b1;
            end
            ST_TCN: begin
               s.new_info = 1'b0;
               s.tx_count = s.tx_count + 4'd1;
               kind       = KIND_TCN;
            end
            ST_RSTP: begin
               s.new_info      = 1'b0;
               s.new_info_msti = 1'b0;
               s.tx_count      = s.tx_count + 4'd1;
               kind            = KIND_RSTP;
               tcack           = 1'b1;
            end
            ST_AGREE: begin
               s.agree_digest_valid = 1'b1;
               s.new_info_msti      = 1'b1;
            end
            default: begin
               s.hello_countdown = cfg.hello_time;
            end
         endcase
      end

      nxt_state                = s;
      result.fsm_state_out     = s.fsm_state;
      result.transmit_kind     = kind;
      result.tx_count_out      = s.tx_count;
      result.new_info_out      = s.new_info;
      result.new_info_msti_out = s.new_info_msti;
      result.tc_ack_clear      = tcack;
      result.agree_digest_out  = s.agree_digest_valid;
   end

endmodule

>>> src/stp_port_transmit_fsm.sv
// Top level of the spanning-tree port transmit machine.
// Depends on stptx_pkg, stptx_if, stptx_csr and stptx_eval.
//
//   channel   dir   handshake            payload
//   req_ch    in    valid/ready          one evaluation word (role bits, tick, flags)
//   rsp_ch    out   valid/ready          state, BPDU kind, tx count, flags
//   csr_*     in    APB psel/penable     tx_hold_count @0x0, hello_time @0x4
//
// One word per clock sustained while rsp_ch takes every response. A word accepted
// into the input register passes through the evaluation logic into the response
// register, updating the machine state as well.
// Synchronous reset puts the machine in init with both new-info flags set.
// A stalled response holds the pipe; the input register still takes a word
// while the response slot is full, and req_ch.ready drops only when both are
// full and the response word is not being taken.
module stp_port_transmit_fsm
   import stptx_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   stptx_req_if.sink   req_ch,
   stptx_rsp_if.source rsp_ch,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type        cfg;
   req_word_type   req_word;
   req_word_type   req_ff, req_in;
   logic           in_valid_ff, in_valid_in;
   rsp_word_type   rsp_ff, rsp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   port_state_type state_ff, state_in;
   port_state_type eval_state;
   rsp_word_type   eval_result;
   logic           out_free;
   logic           advance;
   logic           req_take;

   stptx_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Pack the incoming word
   assign req_word.begin_req             = req_ch.begin_req;
   assign req_word.port_enabled          = req_ch.port_enabled;
   assign req_word.enable_bpdu_tx        = req_ch.enable_bpdu_tx;
   assign req_word.all_transmit_ready    = req_ch.all_transmit_ready;
   assign req_word.cist_role             = req_ch.cist_role;
   assign req_word.msti_master           = req_ch.msti_master;
   assign req_word.msti_desig_or_tc_root = req_ch.msti_desig_or_tc_root;
   assign req_word.cist_tc_active        = req_ch.cist_tc_active;
   assign req_word.spt_all_agree         = req_ch.spt_all_agree;
   assign req_word.send_rstp             = req_ch.send_rstp;
   assign req_word.tick                  = req_ch.tick;
   assign req_word.flag_updates          = req_ch.flag_updates;

   // Advance the held word whenever the response slot is empty or being drained
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;
   assign advance      = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_take     = req_ch.valid && req_ch.ready;

   stptx_eval u_eval (
      .cur_state (state_ff),
      .word      (req_ff),
      .cfg       (cfg),
      .nxt_state (eval_state),
      .result    (eval_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      req_in       = req_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      state_in     = state_ff;
      if (req_ch.ready) in_valid_in = req_ch.valid;
      if (req_take)     req_in      = req_word;
      if (out_free)     rsp_valid_in = in_valid_ff;
      // Commit the evaluation: new machine state and its response together
      if (advance) begin
         rsp_in   = eval_result;
         state_in = eval_state;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                 <= 1'b0;
         rsp_valid_ff                <= 1'b0;
         state_ff.fsm_state          <= ST_INIT;
         state_ff.new_info           <= 1'b1;
         state_ff.new_info_msti      <= 1'b1;
         state_ff.tx_count           <= 4'd0;
         state_ff.hello_countdown    <= 4'd0;
         state_ff.agree_digest_valid <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         state_ff     <= state_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.fsm_state_out     = rsp_ff.fsm_state_out;
   assign rsp_ch.transmit_kind     = rsp_ff.transmit_kind;
   assign rsp_ch.tx_count_out      = rsp_ff.tx_count_out;
   assign rsp_ch.new_info_out      = rsp_ff.new_info_out;
   assign rsp_ch.new_info_msti_out = rsp_ff.new_info_msti_out;
   assign rsp_ch.tc_ack_clear      = rsp_ff.tc_ack_clear;
   assign rsp_ch.agree_digest_out  = rsp_ff.agree_digest_out;

   // A committed evaluation always shows up as a response next cycle
   a_advance_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("evaluation committed without a response");

   // The spare state code is never entered
   a_no_unused_state: assert property (@(posedge clock) disable iff (reset)
      state_ff.fsm_state != ST_UNUSED)
      else $error("machine reached the unused state code");

   // A reported BPDU kind matches the transmit state it was sent from
   a_kind_matches_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.transmit_kind != KIND_NONE |->
         (rsp_ff.transmit_kind == KIND_CONFIG && rsp_ff.fsm_state_out == ST_CONFIG) ||
         (rsp_ff.transmit_kind == KIND_TCN    && rsp_ff.fsm_state_out == ST_TCN) ||
         (rsp_ff.transmit_kind == KIND_RSTP   && rsp_ff.fsm_state_out == ST_RSTP))
      else $error("BPDU kind disagrees with state");

   // tcAck is cleared only by config or rstp transmission
   a_tcack_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.tc_ack_clear |->
         rsp_ff.transmit_kind == KIND_CONFIG || rsp_ff.transmit_kind == KIND_RSTP)
      else $error("tcAck cleared without config or rstp BPDU");

   // Machine state moves only when an evaluation commits
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(state_ff))
      else $error("machine state changed without an evaluation");

endmodule
